FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Both macros expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define HSFD_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define HSFD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/hsfd_pkg.sv
package hsfd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam logic [2:0] POS_T_MSB = 3'd0;
  localparam logic [2:0] POS_T_LSB = 3'd1;
  localparam logic [2:0] POS_T_CRC = 3'd2;
  localparam logic [2:0] POS_H_MSB = 3'd3;
  localparam logic [2:0] POS_H_LSB = 3'd4;
  localparam logic [2:0] POS_H_CRC = 3'd5;

  typedef logic [1:0] status_t;
  localparam status_t STATUS_OK       = 2'd0;
  localparam status_t STATUS_TEMP_CRC = 2'd1;
  localparam status_t STATUS_HUM_CRC  = 2'd2;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

  localparam logic signed [14:0] TEMP_MIN = -15'sd4500;
  localparam logic signed [14:0] TEMP_MAX = 15'sd13000;
  localparam logic [13:0]        HUM_MAX  = 14'd10000;

  typedef struct packed {
    status_t     status;
    logic [15:0] raw_t;
    logic [15:0] raw_h;
  } frame_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // x = 65536*q + r = 65535*q + (q + r), and q + r stays below twice 65535,
  // so a single compare corrects the shifted quotient.
  function automatic logic [14:0] div_full_scale(input logic [30:0] x);
    logic [14:0] q;
    logic [16:0] s;
    q = x[30:16];
    s = {2'b00, q} + {1'b0, x[15:0]};
    return q + 15'(s >= {1'b0, FULL_SCALE});
  endfunction

endpackage

FILE: rtl/hsfd_if.sv
interface hsfd_in_if;
  import hsfd_pkg::*;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source(output valid, output data_byte, output frame_start, input ready);
  modport sink(input valid, input data_byte, input frame_start, output ready);
endinterface

interface hsfd_out_if;
  import hsfd_pkg::*;
  logic               valid;
  logic               ready;
  status_t            status;
  logic signed [14:0] temperature_centi;
  logic [13:0]        humidity_centi;
  logic [15:0]        raw_temperature;
  logic [15:0]        raw_humidity;

  modport source(output valid, output status, output temperature_centi,
                 output humidity_centi, output raw_temperature, output raw_humidity,
                 input ready);
  modport sink(input valid, input status, input temperature_centi,
               input humidity_centi, input raw_temperature, input raw_humidity,
               output ready);
endinterface

FILE: rtl/humidity_sensor_frame_decoder_core.sv
// Sensor read-frame decoder with CRC-8 checks and unit conversion.
// The in_ch channel takes one frame byte per word, in bus order: temperature
// MSB, LSB, CRC, then humidity MSB, LSB, CRC. A word with frame_start set is
// taken as the first byte of a new frame and drops any partial frame.
// The out_ch channel gives one word per complete frame: the status, the
// converted temperature and humidity in hundredths, and both raw words.
// Bytes are taken one per cycle while the queue is not full; the CRC update
// is done in the cycle the byte arrives. The result reaches out_ch through
// the two-entry frame queue and the multiplier stage, followed by the
// output register that holds the quotient.
// The back end takes one result per cycle while out_ch.ready is high, so
// it limits the frame rate only when the receiver stalls.
// When the receiver stalls, finished frames fill the output register, the
// multiplier stage and the queue; input bytes keep being accepted until the
// queue is full, and in_ch.ready stays low only while it is.
// Synchronous reset initialises the byte position, the running CRC, the error
// flag, the queue and all valid flags, so no word is offered after reset.
`include "assert_macros.svh"

module humidity_sensor_frame_decoder_core (
  input  logic       clk,
  input  logic       rst_n,
  hsfd_in_if.sink    in_ch,
  hsfd_out_if.source out_ch
);
  import hsfd_pkg::*;

  logic       push;
  logic       pop;
  frame_rec_t push_rec;
  frame_rec_t head;
  q_stat_t    q_stat;

  hsfd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .q_stat   (q_stat),
    .push     (push),
    .push_rec (push_rec)
  );

  hsfd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head     (head),
    .q_stat   (q_stat)
  );

  hsfd_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

  `HSFD_ASSERT_IMPL(a_queue_stat, 1'b1, !(q_stat.full && q_stat.empty))
  `HSFD_ASSERT_NEXT(a_push_fills, push, !q_stat.empty)
  `HSFD_ASSERT_IMPL(a_temp_range, out_ch.valid,
                    (out_ch.temperature_centi >= TEMP_MIN) && (out_ch.temperature_centi <= TEMP_MAX))
  `HSFD_ASSERT_IMPL(a_hum_range, out_ch.valid, out_ch.humidity_centi <= HUM_MAX)

endmodule

FILE: rtl/hsfd_front.sv
module hsfd_front (
  input  logic                 clk,
  input  logic                 rst_n,
  hsfd_in_if.sink              in_ch,
  input  hsfd_pkg::q_stat_t    q_stat,
  output logic                 push,
  output hsfd_pkg::frame_rec_t push_rec
);
  import hsfd_pkg::*;

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic        t_bad_r, t_bad_nxt;
  logic [15:0] t_word_r, t_word_nxt;
  logic [15:0] h_word_r, h_word_nxt;

  logic       accept;
  logic [2:0] pos;
  logic [7:0] b;
  logic [7:0] crc_in;
  logic [7:0] crc_upd;

  assign in_ch.ready = !q_stat.full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.data_byte;
  assign pos         = (in_ch.frame_start || pos_r > POS_H_CRC) ? POS_T_MSB : pos_r;
  assign crc_in      = (pos == POS_T_MSB) ? CRC_INIT : crc_r;
  assign crc_upd     = crc8_update(crc_in, b);

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    t_bad_nxt  = t_bad_r;
    t_word_nxt = t_word_r;
    h_word_nxt = h_word_r;
    push       = 1'b0;
    if (accept) begin
      unique case (pos)
        POS_T_MSB: begin
          crc_nxt    = crc_upd;
          t_word_nxt = {b, t_word_r[7:0]};
          pos_nxt    = POS_T_LSB;
        end
        POS_T_LSB: begin
          crc_nxt    = crc_upd;
          t_word_nxt = {t_word_r[15:8], b};
          pos_nxt    = POS_T_CRC;
        end
        POS_T_CRC: begin
          t_bad_nxt = (crc_r != b);
          crc_nxt   = CRC_INIT;
          pos_nxt   = POS_H_MSB;
        end
        POS_H_MSB: begin
          crc_nxt    = crc_upd;
          h_word_nxt = {b, h_word_r[7:0]};
          pos_nxt    = POS_H_LSB;
        end
        POS_H_LSB: begin
          crc_nxt    = crc_upd;
          h_word_nxt = {h_word_r[15:8], b};
          pos_nxt    = POS_H_CRC;
        end
        POS_H_CRC: begin
          push      = 1'b1;
          crc_nxt   = CRC_INIT;
          t_bad_nxt = 1'b0;
          pos_nxt   = POS_T_MSB;
        end
        default: begin
          pos_nxt = POS_T_MSB;
        end
      endcase
    end
  end

  always_comb begin
    priority if (t_bad_r) begin
      push_rec.status = STATUS_TEMP_CRC;
    end else if (crc_r != b) begin
      push_rec.status = STATUS_HUM_CRC;
    end else begin
      push_rec.status = STATUS_OK;
    end
    push_rec.raw_t = t_word_r;
    push_rec.raw_h = h_word_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= POS_T_MSB;
      crc_r   <= CRC_INIT;
      t_bad_r <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      t_bad_r <= t_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_word_r <= t_word_nxt;
    h_word_r <= h_word_nxt;
  end

endmodule

FILE: rtl/hsfd_queue.sv
module hsfd_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  hsfd_pkg::frame_rec_t push_rec,
  input  logic                 pop,
  output hsfd_pkg::frame_rec_t head,
  output hsfd_pkg::q_stat_t    q_stat
);
  import hsfd_pkg::*;

  frame_rec_t  entry_r [2];
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]  count_r, count_nxt;
  logic        do_push;
  logic        do_pop;

  assign q_stat.full  = (count_r == 2'd2);
  assign q_stat.empty = (count_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: rtl/hsfd_back.sv
module hsfd_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  hsfd_pkg::frame_rec_t head,
  input  hsfd_pkg::q_stat_t    q_stat,
  output logic                 pop,
  hsfd_out_if.source           out_ch
);
  import hsfd_pkg::*;

  logic        s1_valid_r, s1_valid_nxt;
  status_t     s1_status_r;
  logic [15:0] s1_raw_t_r;
  logic [15:0] s1_raw_h_r;
  logic [30:0] s1_prod_t_r;
  logic [29:0] s1_prod_h_r;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r;
  logic signed [14:0] out_temp_r;
  logic [13:0]        out_hum_r;
  logic [15:0]        out_raw_t_r;
  logic [15:0]        out_raw_h_r;

  logic        out_adv;
  logic        s1_adv;
  logic [14:0] t_div;
  logic [14:0] h_div;

  assign out_adv = !out_valid_r || out_ch.ready;
  assign s1_adv  = !s1_valid_r || out_adv;
  assign pop     = s1_adv && !q_stat.empty;

  assign t_div = div_full_scale(s1_prod_t_r);
  assign h_div = div_full_scale({1'b0, s1_prod_h_r});

  always_comb begin
    s1_valid_nxt  = s1_adv ? !q_stat.empty : s1_valid_r;
    out_valid_nxt = out_adv ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      s1_status_r <= head.status;
      s1_raw_t_r  <= head.raw_t;
      s1_raw_h_r  <= head.raw_h;
      s1_prod_t_r <= {15'd0, head.raw_t} * {16'd0, TEMP_SCALE};
      s1_prod_h_r <= {14'd0, head.raw_h} * {16'd0, HUM_SCALE};
    end
    if (out_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_temp_r   <= signed'(15'(t_div - TEMP_OFFSET));
      out_hum_r    <= h_div[13:0];
      out_raw_t_r  <= s1_raw_t_r;
      out_raw_h_r  <= s1_raw_h_r;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.status            = out_status_r;
  assign out_ch.temperature_centi = out_temp_r;
  assign out_ch.humidity_centi    = out_hum_r;
  assign out_ch.raw_temperature   = out_raw_t_r;
  assign out_ch.raw_humidity      = out_raw_h_r;

endmodule
